// File: hdl/xhfp_pkg.sv
// Shared types, character codes and helper functions for the frame parser.
package xhfp_pkg;

	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_SEP   = 8'h7C;

	localparam int MIN_COUNT = 10;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_FEND  = 2'd1,
		KIND_FRAME = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK    = 4'd0,
		ST_SHORT = 4'd1,
		ST_START = 4'd2,
		ST_NOSEP = 4'd3,
		ST_DIGIT = 4'd4,
		ST_LEN   = 4'd5,
		ST_ETX   = 4'd6,
		ST_CSUM  = 4'd7,
		ST_ASCII = 4'd8
	} status_t;

	// One queue entry holds everything a single input beat produces.
	typedef struct packed {
		logic       rel_v;
		logic       rel_end;
		logic [7:0] rel_data;
		logic       frame_v;
		status_t    status;
	} qentry_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] n8;
		n8 = {4'b0000, nib};
		return (nib < 4'd10) ? (CH_0 + n8) : (CH_LO_A + n8 - 8'd10);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= CH_UP_A && b <= CH_UP_Z) ? (b + 8'd32) : b;
	endfunction

endpackage

// File: hdl/xhfp_front.sv
// Front end: accepts bytes, tracks frame state and classifies each beat.
module xhfp_front #(
	parameter int LEN_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               last,
	input  logic               q_full,
	output logic               push,
	output xhfp_pkg::qentry_t  push_entry
);
	import xhfp_pkg::*;

	localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

	logic [7:0]           td0_q, td1_q, td2_q;
	logic [LEN_WIDTH-1:0] pos_q, dl_q, sep_pos_q;
	logic                 ovf_q, sep_seen_q;
	logic                 f_start_q, f_digit_q, f_ascii_q;
	logic [7:0]           xor_q;

	logic                 accept, rel_v;
	logic                 f_start_n, f_digit_n, f_ascii_n, sep_seen_n, ovf_n;
	logic [LEN_WIDTH-1:0] dl_n, sep_pos_n, count, pos_inc;
	logic [LEN_WIDTH+3:0] dl_ext, v;
	logic [7:0]           xv;
	logic                 hi_ok, lo_ok;
	status_t              st;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		rel_v     = sep_seen_q && ({1'b0, pos_q} >= ({1'b0, sep_pos_q} + (LEN_WIDTH+1)'(4)));
		f_ascii_n = f_ascii_q | (rel_v & td2_q[7]);
		f_start_n = f_start_q | ((pos_q == '0) && (in_byte != CH_SOH))
			| ((pos_q == LEN_WIDTH'(1)) && (in_byte != CH_STX));
		f_digit_n  = f_digit_q;
		sep_seen_n = sep_seen_q;
		sep_pos_n  = sep_pos_q;
		dl_n       = dl_q;
		ovf_n      = ovf_q;
		dl_ext     = {4'b0000, dl_q};
		v          = (dl_ext << 3) + (dl_ext << 1) + {LEN_WIDTH'(0), in_byte[3:0] - CH_0[3:0]};
		if (pos_q >= LEN_WIDTH'(2) && !sep_seen_q) begin
			if (in_byte == CH_SEP) begin
				sep_seen_n = 1'b1;
				sep_pos_n  = pos_q;
			end else if (in_byte inside {[CH_0:CH_9]}) begin
				if (ovf_q || v >= {4'b0000, LEN_MAX}) begin
					dl_n  = LEN_MAX;
					ovf_n = 1'b1;
				end else begin
					dl_n = v[LEN_WIDTH-1:0];
				end
			end else begin
				f_digit_n = 1'b1;
			end
		end

		pos_inc = (pos_q != LEN_MAX) ? pos_q + LEN_WIDTH'(1) : LEN_MAX;
		count   = pos_inc;
		// The high checksum character was folded into the running XOR; take it back out.
		xv    = xor_q ^ td0_q;
		lo_ok = to_lower(in_byte) == hex_char(xv[3:0]);
		hi_ok = (to_lower(td0_q) == hex_char(xv[7:4])) || (td0_q == CH_SPACE);

		if (count < LEN_WIDTH'(MIN_COUNT))                          st = ST_SHORT;
		else if (f_start_n)                                         st = ST_START;
		else if (!sep_seen_n)                                       st = ST_NOSEP;
		else if (f_digit_n)                                         st = ST_DIGIT;
		else if (ovf_n || count == LEN_MAX || dl_n != count)        st = ST_LEN;
		else if (td1_q != CH_ETX)                                   st = ST_ETX;
		else if (!(hi_ok && lo_ok))                                 st = ST_CSUM;
		else if (f_ascii_n)                                         st = ST_ASCII;
		else                                                        st = ST_OK;

		push_entry.rel_v    = rel_v;
		push_entry.rel_end  = (td2_q == CH_SEP);
		push_entry.rel_data = (td2_q == CH_SEP) ? 8'h00 : td2_q;
		push_entry.frame_v  = last;
		push_entry.status   = st;
		push = accept && (rel_v || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			td0_q <= '0; td1_q <= '0; td2_q <= '0;
			pos_q <= '0; dl_q <= '0; sep_pos_q <= '0;
			ovf_q <= 1'b0; sep_seen_q <= 1'b0;
			f_start_q <= 1'b0; f_digit_q <= 1'b0; f_ascii_q <= 1'b0;
			xor_q <= '0;
		end else if (accept) begin
			if (last) begin
				td0_q <= '0; td1_q <= '0; td2_q <= '0;
				pos_q <= '0; dl_q <= '0; sep_pos_q <= '0;
				ovf_q <= 1'b0; sep_seen_q <= 1'b0;
				f_start_q <= 1'b0; f_digit_q <= 1'b0; f_ascii_q <= 1'b0;
				xor_q <= '0;
			end else begin
				td0_q <= in_byte; td1_q <= td0_q; td2_q <= td1_q;
				pos_q <= pos_inc; dl_q <= dl_n; sep_pos_q <= sep_pos_n;
				ovf_q <= ovf_n; sep_seen_q <= sep_seen_n;
				f_start_q <= f_start_n; f_digit_q <= f_digit_n; f_ascii_q <= f_ascii_n;
				xor_q <= xor_q ^ in_byte;
			end
		end
	end

endmodule

// File: hdl/xhfp_queue.sv
// Small FIFO that decouples the classifying front end from the output side.
module xhfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xhfp_pkg::qentry_t push_entry,
	input  logic              pop,
	output xhfp_pkg::qentry_t head,
	output logic              empty,
	output logic              full
);
	import xhfp_pkg::*;

	qentry_t      mem_q [QDEPTH];
	logic [QAW:0] wptr_q, rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[QAW] != rptr_q[QAW]) && (wptr_q[QAW-1:0] == rptr_q[QAW-1:0]);
	assign head  = mem_q[rptr_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q[QAW-1:0]] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + (QAW+1)'(1);
			if (pop)  rptr_q <= rptr_q + (QAW+1)'(1);
		end
	end

endmodule

// File: hdl/xhfp_back.sv
// Back end: unpacks queue entries into result beats through an output register.
module xhfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  xhfp_pkg::qentry_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        data,
	output logic [3:0]        status
);
	import xhfp_pkg::*;

	logic       phase_q;
	logic       load, use_rel, last_part;
	kind_t      cur_kind;
	logic [7:0] cur_data;
	logic [3:0] cur_status;

	assign load = !empty && (!out_valid || out_ready);

	always_comb begin
		// Phase one means the release of this entry already went out.
		use_rel   = !phase_q && head.rel_v;
		last_part = !(use_rel && head.frame_v);
		if (use_rel) begin
			cur_kind   = head.rel_end ? KIND_FEND : KIND_CHAR;
			cur_data   = head.rel_data;
			cur_status = ST_OK;
		end else begin
			cur_kind   = KIND_FRAME;
			cur_data   = 8'h00;
			cur_status = head.status;
		end
		pop = load && last_part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				phase_q   <= !last_part;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind   <= cur_kind;
			data   <= cur_data;
			status <= cur_status;
		end
	end

endmodule

// File: hdl/xor_hex_frame_parser_top.sv
// Top level of the framed-message parser with XOR hex checksum.
//
// The parser takes one byte per clock and gives up to one result per clock. Body bytes come
// out three bytes late as field characters or field ends, and the last byte of a frame gives
// a frame-end result with the status; a beat that causes both a release and the frame end
// gives two results, the release first. A result is written into the queue when its input
// beat is accepted and is later loaded from there into the output register. The front end
// updates all frame state in the accepting cycle and writes the beat's results into a
// four-entry queue; the back end drains that queue into the output register, so the input
// stalls only when the queue is full.
module xor_hex_frame_parser_top #(
	parameter int LEN_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic [3:0] status
);
	import xhfp_pkg::*;

	logic    push, pop, q_empty, q_full;
	qentry_t push_entry, head;

	xhfp_front #(.LEN_WIDTH(LEN_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte, .last,
		.q_full, .push, .push_entry
	);

	xhfp_queue u_queue (
		.clk, .arst_n, .push, .push_entry, .pop, .head,
		.empty(q_empty), .full(q_full)
	);

	xhfp_back u_back (
		.clk, .arst_n, .head, .empty(q_empty), .pop,
		.out_valid, .out_ready, .kind, .data, .status
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("queue read while empty");

	a_body_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_FRAME)
			|-> (status == ST_OK) && (kind == KIND_CHAR || data == 8'h00))
		else $error("body beat carries status or stray data");

	a_frame_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_FRAME) |-> (data == 8'h00) && (status <= ST_ASCII))
		else $error("frame-end beat malformed");

endmodule
